// File: rtl/s_curve_step_pulse_generator_assert.svh
// assertion helpers shared by the checker
`ifndef S_CURVE_STEP_PULSE_GENERATOR_ASSERT_SVH
`define S_CURVE_STEP_PULSE_GENERATOR_ASSERT_SVH

// same-cycle implication, masked during reset
`define SCSPG_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define SCSPG_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/scspg_pkg.sv
package scspg_pkg;

    localparam logic signed [63:0] SAT_CAP    = 64'sh2000_0000_0000_0000;
    localparam logic [61:0]        MUL_CAP    = 62'h2000_0000_0000_0000;
    localparam logic [31:0]        PERIOD_NUM = 32'd256_000_000;
    localparam int                 PERIOD_W   = 20;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_US = 20'd10;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_US = 20'd1_000_000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_CRUISE = 3'd2,
        PH_DECEL  = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        REG_MOVE_STEPS   = 3'd0,
        REG_ACCEL_STEPS  = 3'd1,
        REG_CRUISE_STEPS = 3'd2,
        REG_MAX_SPEED    = 3'd3,
        REG_START_SPEED  = 3'd4,
        REG_START_ACCEL  = 3'd5,
        REG_MAX_ACCEL    = 3'd6,
        REG_JERK_RATE    = 3'd7
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_PJ, S_PQ1, S_PQ2, S_PSA, S_PC, S_SEL, S_A1M, S_Q1, S_Q2,
        S_L2, S_T1, S_T2, S_T3, S_T4, S_T5, S_PER, S_SPER, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        R_ZERO, R_VMAX, R_A1, R_A2, R_A3, R_D1, R_D2, R_D3
    } t_region;

    typedef struct packed {
        logic [31:0] move_steps;
        logic [31:0] accel_steps;
        logic [31:0] cruise_steps;
        logic [31:0] max_speed;
        logic [31:0] start_speed;
        logic [31:0] start_accel;
        logic [31:0] max_accel;
        logic [31:0] jerk_rate;
    } t_cfg;

    typedef struct packed {
        t_state step;
        logic   go_mul;
        logic   go_div;
        logic   cap;
        logic   take;
    } t_ctl;

    typedef struct packed {
        logic    mul_done;
        logic    div_done;
        logic    prep_ok;
        logic    need_eval;
        logic    is_start;
        logic    out_free;
        t_region region;
    } t_sts;

    function automatic logic signed [63:0] sat61(input logic signed [63:0] x);
        if (x > SAT_CAP) begin
            return SAT_CAP;
        end else if (x < -SAT_CAP) begin
            return -SAT_CAP;
        end
        return x;
    endfunction

endpackage

// File: rtl/scspg_mul.sv
module scspg_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [61:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [61:0] o_res
);
    import scspg_pkg::*;

    logic [61:0] r_a;
    logic [31:0] r_b;
    logic [63:0] r_lo;
    logic [61:0] r_hi;
    logic [61:0] r_res;
    logic        r_v1, r_v2, r_v3, r_done;
    logic [94:0] w_sum;

    // low and high partial products on successive cycles, then saturate
    assign w_sum = {1'b0, r_hi, 32'b0} + {31'b0, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_go;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_v1) begin
            r_lo <= r_a[31:0] * r_b;
        end
        if (r_v2) begin
            r_hi <= r_a[61:32] * r_b;
        end
        if (r_v3) begin
            r_res <= (w_sum > {33'b0, MUL_CAP}) ? MUL_CAP : w_sum[61:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// File: rtl/scspg_div.sv
module scspg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo
);
    import scspg_pkg::*;

    localparam logic [5:0] DIV_STEPS = 6'd32;

    logic [31:0] r_rem, r_quo, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] w_sh, w_dif;
    logic        w_ge;

    // restoring division, one quotient bit a cycle; zero divisor gives all ones
    assign w_sh  = {r_rem, r_quo[31]};
    assign w_ge  = w_sh >= {1'b0, r_den};
    assign w_dif = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_dif[31:0] : w_sh[31:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: rtl/scspg_dp.sv
module scspg_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  scspg_pkg::t_cfg         i_cfg,
    input  logic                    i_cfg_wr,
    input  scspg_pkg::t_ctl         i_ctl,
    output scspg_pkg::t_sts         o_sts,
    input  logic [1:0]              i_command,
    input  logic                    i_move_direction,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic                    o_step_pulse,
    output logic                    o_dir_level,
    output logic                    o_driver_enable,
    output logic [2:0]              o_motion_phase,
    output logic [19:0]             o_period_us,
    output logic [31:0]             o_steps_done,
    output logic                    o_move_done
);
    import scspg_pkg::*;

    // move state
    logic        r_running, r_finished, r_dir, r_pulse, r_prep_ok;
    logic [31:0] r_count;
    logic [63:0] r_elapsed, r_due;
    logic [PERIOD_W-1:0] r_period;
    t_phase      r_phase;
    // profile constants and work registers
    logic [31:0] r_j, r_c, r_x, r_d;
    logic [61:0] r_sj, r_qj, r_m;
    logic signed [63:0] r_acc, r_t, r_v;
    t_region     r_region;
    // result register
    logic        r_out_valid, r_o_pulse, r_o_dir, r_o_en, r_o_done;
    logic [2:0]  r_o_phase;
    logic [PERIOD_W-1:0] r_o_period;
    logic [31:0] r_o_steps;

    logic [61:0] w_mul_a, w_mul_res;
    logic [31:0] w_mul_b, w_div_num, w_div_den, w_div_q;
    logic        w_mul_done, w_div_done;
    logic [32:0] w_ac_sum, w_e_full, w_jc;
    logic [31:0] w_x;
    logic        w_accel, w_past_cruise;
    t_region     w_region;
    logic signed [63:0] w_res, w_half, w_vmax, w_ss, w_sj, w_qj, w_vq, w_num, w_tt, w_sum_t;
    logic [PERIOD_W-1:0] w_per;
    t_cmd        w_cmd;

    function automatic logic signed [63:0] lim_hi(input logic signed [63:0] x,
                                                   input logic signed [63:0] top);
        return (x > top) ? top : x;
    endfunction

    function automatic logic signed [63:0] lim_lo(input logic signed [63:0] x);
        return (x > 64'sd0) ? x : 64'sd0;
    endfunction

    scspg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctl.go_mul),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    scspg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_ctl.go_div),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    assign w_cmd  = t_cmd'(i_command);
    assign w_res  = signed'({2'b0, w_mul_res});
    assign w_half = signed'({3'b0, w_mul_res[61:1]});
    assign w_vmax = signed'({32'b0, i_cfg.max_speed});
    assign w_ss   = signed'({32'b0, i_cfg.start_speed});
    assign w_sj   = signed'({2'b0, r_sj});
    assign w_qj   = signed'({2'b0, r_qj});
    assign w_vq   = sat61(w_vmax - w_qj);
    assign w_num  = w_vmax - w_sj;

    // region of the profile for the current step count
    assign w_ac_sum      = {1'b0, i_cfg.accel_steps} + {1'b0, i_cfg.cruise_steps};
    assign w_e_full      = {1'b0, r_count} - w_ac_sum;
    assign w_accel       = r_count < i_cfg.accel_steps;
    assign w_past_cruise = {1'b0, r_count} >= w_ac_sum;
    assign w_x           = w_accel ? r_count : w_e_full[31:0];
    assign w_jc          = {1'b0, r_j} + {1'b0, r_c};

    always_comb begin
        if (r_count >= i_cfg.move_steps) begin
            w_region = R_ZERO;
        end else if (!w_accel && !w_past_cruise) begin
            w_region = R_VMAX;
        end else if (w_x < r_j) begin
            w_region = w_accel ? R_A1 : R_D1;
        end else if ({1'b0, w_x} < w_jc) begin
            w_region = w_accel ? R_A2 : R_D2;
        end else begin
            w_region = w_accel ? R_A3 : R_D3;
        end
    end

    // operand selection for the shared units
    always_comb begin
        w_mul_a = {30'b0, i_cfg.jerk_rate};
        w_mul_b = r_x;
        unique case (i_ctl.step)
            S_PQ1:   w_mul_b = r_j;
            S_PQ2:   begin w_mul_a = r_m; w_mul_b = r_j; end
            S_PSA:   begin w_mul_a = {30'b0, i_cfg.start_accel}; w_mul_b = r_j; end
            S_A1M:   w_mul_a = {30'b0, i_cfg.start_accel};
            S_Q2:    w_mul_a = r_m;
            S_L2:    begin w_mul_a = {30'b0, i_cfg.max_accel}; w_mul_b = r_x - r_j; end
            S_T1:    begin w_mul_a = {30'b0, i_cfg.max_accel}; w_mul_b = r_c; end
            S_T2:    begin w_mul_a = {30'b0, i_cfg.max_accel}; w_mul_b = 32'd2; end
            S_T3:    begin w_mul_a = r_m; w_mul_b = r_d; end
            S_T4:    w_mul_b = r_d;
            S_T5:    begin w_mul_a = r_m; w_mul_b = r_d; end
            default: w_mul_b = r_x;
        endcase
    end

    always_comb begin
        unique case (i_ctl.step)
            S_PJ: begin
                w_div_num = i_cfg.max_accel;
                w_div_den = i_cfg.jerk_rate;
            end
            S_PC: begin
                w_div_num = (w_num > 64'sd0) ? w_num[31:0] : 32'd0;
                w_div_den = i_cfg.max_accel;
            end
            default: begin
                w_div_num = PERIOD_NUM;
                w_div_den = r_v[31:0];
            end
        endcase
    end

    // period from speed, clamped
    always_comb begin
        if (r_v <= 64'sd0) begin
            w_per = MAX_PERIOD_US;
        end else if (r_v > signed'({32'b0, PERIOD_NUM})) begin
            w_per = MIN_PERIOD_US;
        end else if (w_div_q > {12'b0, MAX_PERIOD_US}) begin
            w_per = MAX_PERIOD_US;
        end else if (w_div_q < {12'b0, MIN_PERIOD_US}) begin
            w_per = MIN_PERIOD_US;
        end else begin
            w_per = w_div_q[PERIOD_W-1:0];
        end
    end

    // final term of the release and tail segments
    assign w_tt    = (r_region == R_A3) ? (r_t - w_res) : (w_res - r_t);
    assign w_sum_t = sat61(r_acc + (w_tt >>> 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_finished <= 1'b0;
            r_dir      <= 1'b0;
            r_count    <= '0;
            r_elapsed  <= '0;
            r_due      <= '0;
            r_period   <= '0;
            r_phase    <= PH_IDLE;
            r_pulse    <= 1'b0;
            r_prep_ok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.take) begin
                r_pulse <= 1'b0;
                case (w_cmd)
                    CMD_START: begin
                        r_dir     <= i_move_direction;
                        r_count   <= '0;
                        r_elapsed <= '0;
                        r_due     <= '0;
                        if (i_cfg.move_steps == 32'd0) begin
                            r_running  <= 1'b0;
                            r_finished <= 1'b1;
                            r_phase    <= PH_DONE;
                        end else begin
                            r_running  <= 1'b1;
                            r_finished <= 1'b0;
                            r_phase    <= PH_ACCEL;
                        end
                    end
                    CMD_STOP: begin
                        if (r_running) begin
                            r_running <= 1'b0;
                            r_phase   <= PH_IDLE;
                        end
                    end
                    CMD_TICK: begin
                        if (r_running) begin
                            r_elapsed <= r_elapsed + 64'd1;
                            if (r_elapsed >= r_due) begin
                                r_pulse <= 1'b1;
                                r_count <= r_count + 32'd1;
                            end
                        end
                    end
                    default: r_pulse <= 1'b0;
                endcase
            end
            if (i_ctl.cap && i_ctl.step == S_PC) begin
                r_prep_ok <= 1'b1;
            end
            if (i_cfg_wr) begin
                r_prep_ok <= 1'b0;
            end
            if (i_ctl.cap && i_ctl.step == S_SPER) begin
                r_period <= w_per;
            end
            if (i_ctl.cap && i_ctl.step == S_PER) begin
                r_period <= w_per;
                r_due    <= r_due + {44'b0, w_per};
                if (r_count >= i_cfg.move_steps) begin
                    r_running  <= 1'b0;
                    r_finished <= 1'b1;
                    r_phase    <= PH_DONE;
                end else if (w_accel) begin
                    r_phase <= PH_ACCEL;
                end else if (!w_past_cruise) begin
                    r_phase <= PH_CRUISE;
                end else begin
                    r_phase <= PH_DECEL;
                end
            end
            if (i_ctl.cap && i_ctl.step == S_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // work registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.take && w_cmd == CMD_START) begin
            r_v <= w_ss;
        end
        if (i_ctl.cap) begin
            unique case (i_ctl.step)
                S_PJ:  r_j  <= w_div_q;
                S_PQ1: r_m  <= w_mul_res;
                S_PQ2: r_qj <= {1'b0, w_mul_res[61:1]};
                S_PSA: r_sj <= sat61(sat61(w_ss + w_res) + w_qj)[61:0];
                S_PC:  r_c  <= (w_num > 64'sd0) ? w_div_q : 32'd0;
                S_SEL: begin
                    r_region <= w_region;
                    r_x      <= w_x;
                    r_d      <= w_x - r_j - r_c;
                    if (w_region == R_ZERO) begin
                        r_v <= 64'sd0;
                    end else if (w_region == R_VMAX) begin
                        r_v <= w_vmax;
                    end
                end
                S_A1M: r_acc <= sat61(w_ss + w_res);
                S_Q1:  r_m   <= w_mul_res;
                S_Q2: begin
                    if (r_region == R_A1) begin
                        r_v <= lim_hi(sat61(r_acc + w_half), w_vmax);
                    end else begin
                        r_v <= lim_lo(sat61(w_vmax - w_half));
                    end
                end
                S_L2: begin
                    if (r_region == R_A2) begin
                        r_v <= lim_hi(sat61(w_sj + w_res), w_vmax);
                    end else begin
                        r_v <= lim_lo(sat61(w_vq - w_res));
                    end
                end
                S_T1: r_acc <= (r_region == R_A3) ? sat61(w_sj + w_res) : sat61(w_vq - w_res);
                S_T2: r_m   <= w_mul_res;
                S_T3: r_t   <= w_res;
                S_T4: r_m   <= w_mul_res;
                S_T5: r_v   <= (r_region == R_A3) ? lim_hi(w_sum_t, w_vmax) : lim_lo(w_sum_t);
                S_OUT: begin
                    r_o_pulse  <= r_pulse;
                    r_o_dir    <= r_dir;
                    r_o_en     <= r_running;
                    r_o_phase  <= r_phase;
                    r_o_period <= r_period;
                    r_o_steps  <= r_count;
                    r_o_done   <= r_finished;
                end
                default: r_m <= r_m;
            endcase
        end
    end

    assign o_sts.mul_done  = w_mul_done;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.prep_ok   = r_prep_ok;
    assign o_sts.need_eval = (w_cmd == CMD_TICK) && r_running && (r_elapsed >= r_due);
    assign o_sts.is_start  = (w_cmd == CMD_START);
    assign o_sts.out_free  = !r_out_valid || !i_stall;
    assign o_sts.region    = w_region;

    assign o_valid         = r_out_valid;
    assign o_step_pulse    = r_o_pulse;
    assign o_dir_level     = r_o_dir;
    assign o_driver_enable = r_o_en;
    assign o_motion_phase  = r_o_phase;
    assign o_period_us     = r_o_period;
    assign o_steps_done    = r_o_steps;
    assign o_move_done     = r_o_done;
endmodule

// File: rtl/scspg_ctrl.sv
module scspg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  scspg_pkg::t_sts i_sts,
    output scspg_pkg::t_ctl o_ctl
);
    import scspg_pkg::*;

    typedef enum logic [1:0] {U_NONE, U_MUL, U_DIV} t_unit;

    t_state r_state, n_state;
    logic   r_issued;
    t_unit  w_unit;
    logic   w_adv;

    function automatic t_unit unit_of(input t_state s);
        unique case (s)
            S_PJ, S_PC, S_PER, S_SPER: return U_DIV;
            S_PQ1, S_PQ2, S_PSA, S_A1M, S_Q1, S_Q2, S_L2,
            S_T1, S_T2, S_T3, S_T4, S_T5: return U_MUL;
            default: return U_NONE;
        endcase
    endfunction

    assign w_unit = unit_of(r_state);

    // a step completes on unit done, S_OUT on free output, others at once
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_adv = 1'b0;
            S_OUT:   w_adv = i_sts.out_free;
            default: begin
                if (w_unit == U_NONE) begin
                    w_adv = 1'b1;
                end else if (w_unit == U_MUL) begin
                    w_adv = r_issued && i_sts.mul_done;
                end else begin
                    w_adv = r_issued && i_sts.div_done;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.need_eval) begin
                        n_state = i_sts.prep_ok ? S_SEL : S_PJ;
                    end else if (i_sts.is_start) begin
                        n_state = S_SPER;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_PJ:  if (w_adv) n_state = S_PQ1;
            S_PQ1: if (w_adv) n_state = S_PQ2;
            S_PQ2: if (w_adv) n_state = S_PSA;
            S_PSA: if (w_adv) n_state = S_PC;
            S_PC:  if (w_adv) n_state = S_SEL;
            S_SEL: begin
                case (i_sts.region)
                    R_A1:       n_state = S_A1M;
                    R_D1:       n_state = S_Q1;
                    R_A2, R_D2: n_state = S_L2;
                    R_A3, R_D3: n_state = S_T1;
                    default:    n_state = S_PER;
                endcase
            end
            S_A1M: if (w_adv) n_state = S_Q1;
            S_Q1:  if (w_adv) n_state = S_Q2;
            S_Q2:  if (w_adv) n_state = S_PER;
            S_L2:  if (w_adv) n_state = S_PER;
            S_T1:  if (w_adv) n_state = S_T2;
            S_T2:  if (w_adv) n_state = S_T3;
            S_T3:  if (w_adv) n_state = S_T4;
            S_T4:  if (w_adv) n_state = S_T5;
            S_T5:  if (w_adv) n_state = S_PER;
            S_PER: if (w_adv) n_state = S_OUT;
            S_SPER: if (w_adv) n_state = S_OUT;
            S_OUT: if (w_adv) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl.step   = r_state;
        o_ctl.take   = (r_state == S_IDLE) && i_valid;
        o_ctl.go_mul = (w_unit == U_MUL) && !r_issued;
        o_ctl.go_div = (w_unit == U_DIV) && !r_issued;
        o_ctl.cap    = w_adv;
        o_stall      = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_issued <= 1'b0;
            end else if (o_ctl.go_mul || o_ctl.go_div) begin
                r_issued <= 1'b1;
            end
        end
    end
endmodule

// File: rtl/s_curve_step_pulse_generator.sv
// tick without a step, stop, no-op: straight to the result register; start: one period division
// step tick: the period division and up to five multiplies, chosen by the profile region;
// the profile prep also runs on the first step after any register write
// throughput: one request at a time, next request taken once the result is in the output register
// reset: synchronous active low, move idle, registers back to defaults, no clearing pass
module s_curve_step_pulse_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic        i_move_direction,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_step_pulse,
    output logic        o_dir_level,
    output logic        o_driver_enable,
    output logic [2:0]  o_motion_phase,
    output logic [19:0] o_period_us,
    output logic [31:0] o_steps_done,
    output logic        o_move_done,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import scspg_pkg::*;

    t_cfg r_cfg;
    t_ctl w_ctl;
    t_sts w_sts;
    logic w_wr;
    t_reg w_idx;

    // register writes complete in the access phase, no wait states
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_steps   <= '0;
            r_cfg.accel_steps  <= '0;
            r_cfg.cruise_steps <= '0;
            r_cfg.max_speed    <= '0;
            r_cfg.start_speed  <= '0;
            r_cfg.start_accel  <= '0;
            r_cfg.max_accel    <= 32'd256;
            r_cfg.jerk_rate    <= 32'd256;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MOVE_STEPS:   r_cfg.move_steps   <= pwdata;
                REG_ACCEL_STEPS:  r_cfg.accel_steps  <= pwdata;
                REG_CRUISE_STEPS: r_cfg.cruise_steps <= pwdata;
                REG_MAX_SPEED:    r_cfg.max_speed    <= pwdata;
                REG_START_SPEED:  r_cfg.start_speed  <= pwdata;
                REG_START_ACCEL:  r_cfg.start_accel  <= pwdata;
                REG_MAX_ACCEL:    r_cfg.max_accel    <= pwdata;
                REG_JERK_RATE:    r_cfg.jerk_rate    <= pwdata;
                default:          r_cfg.jerk_rate    <= r_cfg.jerk_rate;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_idx)
            REG_MOVE_STEPS:   prdata = r_cfg.move_steps;
            REG_ACCEL_STEPS:  prdata = r_cfg.accel_steps;
            REG_CRUISE_STEPS: prdata = r_cfg.cruise_steps;
            REG_MAX_SPEED:    prdata = r_cfg.max_speed;
            REG_START_SPEED:  prdata = r_cfg.start_speed;
            REG_START_ACCEL:  prdata = r_cfg.start_accel;
            REG_MAX_ACCEL:    prdata = r_cfg.max_accel;
            REG_JERK_RATE:    prdata = r_cfg.jerk_rate;
            default:          prdata = '0;
        endcase
    end

    // sequencer for the profile evaluation
    scspg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    // move state, shared multiplier and divider, result register
    scspg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cfg_wr         (w_wr),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_command        (i_command),
        .i_move_direction (i_move_direction),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_step_pulse     (o_step_pulse),
        .o_dir_level      (o_dir_level),
        .o_driver_enable  (o_driver_enable),
        .o_motion_phase   (o_motion_phase),
        .o_period_us      (o_period_us),
        .o_steps_done     (o_steps_done),
        .o_move_done      (o_move_done)
    );
endmodule

// File: rtl/scspg_chk.sv
`include "s_curve_step_pulse_generator_assert.svh"

module scspg_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_command,
    input logic        i_move_direction,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_step_pulse,
    input logic        o_dir_level,
    input logic        o_driver_enable,
    input logic [2:0]  o_motion_phase,
    input logic [19:0] o_period_us,
    input logic [31:0] o_steps_done,
    input logic        o_move_done,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [4:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
    import scspg_pkg::*;

    `SCSPG_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_steps_done) && $stable(o_period_us), "result changed while stalled")
    `SCSPG_HOLDS(a_pulse_run, o_valid && o_step_pulse, o_driver_enable || o_move_done, "step issued outside a move")
    `SCSPG_HOLDS(a_run_phase, o_valid && o_driver_enable, o_motion_phase == PH_ACCEL || o_motion_phase == PH_CRUISE || o_motion_phase == PH_DECEL, "running move in a non-motion phase")
    `SCSPG_HOLDS(a_done_phase, o_valid && o_motion_phase == PH_DONE, o_move_done && !o_driver_enable, "complete phase without done")
    `SCSPG_HOLDS(a_period_rng, o_valid, o_period_us == 20'd0 || (o_period_us >= MIN_PERIOD_US && o_period_us <= MAX_PERIOD_US), "period out of range")
endmodule

bind s_curve_step_pulse_generator scspg_chk u_chk (.*);
